>>> design/scgsf_pkg.sv
`timescale 1ns / 1ps

package scgsf_pkg;

    // Default chain length limit for the top level
    localparam int unsigned MAX_SEEDS_DEF = 1024;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Score width and its saturation value
    localparam int                 SCORE_W   = 48;
    localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_SCORE    = 3'd0,
        CFG_EXTEND_PENALTY = 3'd1,
        CFG_OPEN_PENALTY   = 3'd2,
        CFG_MAX_GAP_AREA   = 3'd3,
        CFG_OPTIMISTIC     = 3'd4
    } t_cfg_reg;

    // Register reset values
    localparam logic [7:0]  MATCH_SCORE_RST    = 8'd2;
    localparam logic [7:0]  EXTEND_PENALTY_RST = 8'd4;
    localparam logic [9:0]  OPEN_PENALTY_RST   = 10'd6;
    localparam logic [31:0] MAX_GAP_AREA_RST   = 32'd0;
    localparam logic        OPTIMISTIC_RST     = 1'b0;

    // One seed of a chain
    typedef struct packed {
        logic [31:0] query_start;
        logic [31:0] ref_start;
        logic [15:0] seed_len;
        logic        first_seed;
        logic        last_seed;
    } t_seed;

    // Chain summary, sent on the last seed
    typedef struct packed {
        logic [9:0]         best_first_index;
        logic [9:0]         best_last_index;
        logic [SCORE_W-1:0] best_score;
        logic [10:0]        seed_count;
    } t_result;

endpackage

>>> design/seed_chain_gap_score_filter.sv
`timescale 1ns / 1ps

// A seed's chain summary reaches o_data through the stage registers and the output register.
// Throughput: one seed per cycle while o_stall is low; the 48-bit score recurrence is two adds,
// a select and a compare against the chain state registers.
// o_stall is raised only while a summary waits in the output register and another last seed
// has reached the score stage. Reset (i_rst_n low, synchronous) empties the pipeline and
// returns registers, previous-seed fields and chain state to their reset values.
module seed_chain_gap_score_filter
    import scgsf_pkg::*;
#(
    parameter int unsigned MAX_SEEDS = MAX_SEEDS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // seed input
    input  logic                  i_valid,
    input  t_seed                 i_data,
    output logic                  o_stall,
    // summary output
    output logic                  o_valid,
    output t_result               o_data,
    input  logic                  i_stall,
    // configuration writes
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    localparam int IDX_W = $clog2(MAX_SEEDS);
    localparam int CNT_W = $clog2(MAX_SEEDS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEEDS);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SEEDS - 1);

    // configuration registers
    logic [7:0]  r_match;
    logic [7:0]  r_ext;
    logic [9:0]  r_open;
    logic [31:0] r_area;
    logic        r_opt;

    // previous seed
    logic [31:0] r_prev_q;
    logic [31:0] r_prev_r;
    logic [15:0] r_prev_len;

    // pipeline control
    logic w_adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: seed and previous seed
    logic [31:0] r_s1_q, r_s1_r, r_s1_pq, r_s1_pr;
    logic [15:0] r_s1_len, r_s1_plen;
    logic        r_s1_first, r_s1_last;

    // stage 2: start differences and previous ends
    logic [31:0] n_s2_dq, n_s2_dr;
    logic [32:0] n_s2_qend, n_s2_rend;
    logic [31:0] r_s2_q, r_s2_r, r_s2_dq, r_s2_dr;
    logic [32:0] r_s2_qend, r_s2_rend;
    logic [15:0] r_s2_len;
    logic        r_s2_first, r_s2_last;

    // stage 3: indel size, diagonal part, axis gaps
    logic [31:0] n_s3_gap, n_s3_diag, n_s3_gy, n_s3_gx;
    logic [31:0] r_s3_gap, r_s3_diag, r_s3_gy, r_s3_gx;
    logic [15:0] r_s3_len;
    logic        r_s3_first, r_s3_last;

    // stage 4: products and area check
    logic [23:0] n_s4_len_prod;
    logic [39:0] n_s4_diag_prod, n_s4_gap_prod;
    logic        n_s4_too_far;
    logic [23:0] r_s4_len_prod;
    logic [39:0] r_s4_diag_prod, r_s4_gap_prod;
    logic        r_s4_too_far, r_s4_first, r_s4_last;

    // stage 5: score increment, cost and net change
    logic [40:0]        n_s5_inc, n_s5_cost;
    logic signed [41:0] n_s5_net;
    logic [SCORE_W-1:0] n_s5_sat_cost;
    logic [40:0]        r_s5_inc;
    logic signed [41:0] r_s5_net;
    logic [SCORE_W-1:0] r_s5_sat_cost;
    logic [23:0]        r_s5_len_prod;
    logic               r_s5_too_far, r_s5_first, r_s5_last;

    // chain state
    logic [SCORE_W-1:0] r_run, r_max, n_run, n_max;
    logic [IDX_W-1:0]   r_seg, r_os, r_oe, n_seg, n_os, n_oe;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SCORE_W:0]   w_sum_a;
    logic signed [SCORE_W+1:0] w_sum_b;
    logic [SCORE_W-1:0] w_kept;
    logic               w_take;
    logic [IDX_W-1:0]   w_idx;
    t_result            n_result;

    // output register
    logic    r_out_valid;
    t_result r_out;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= MATCH_SCORE_RST;
            r_ext   <= EXTEND_PENALTY_RST;
            r_open  <= OPEN_PENALTY_RST;
            r_area  <= MAX_GAP_AREA_RST;
            r_opt   <= OPTIMISTIC_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MATCH_SCORE:    r_match <= i_cfg_data[7:0];
                CFG_EXTEND_PENALTY: r_ext   <= i_cfg_data[7:0];
                CFG_OPEN_PENALTY:   r_open  <= i_cfg_data[9:0];
                CFG_MAX_GAP_AREA:   r_area  <= i_cfg_data[31:0];
                CFG_OPTIMISTIC:     r_opt   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Hold the whole pipeline only when a summary cannot leave the score stage
    assign w_adv   = !(r_v5 && r_s5_last && r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // Advance valid bits and remember the previous seed on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_v5       <= 1'b0;
            r_prev_q   <= '0;
            r_prev_r   <= '0;
            r_prev_len <= '0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (i_valid) begin
                r_prev_q   <= i_data.query_start;
                r_prev_r   <= i_data.ref_start;
                r_prev_len <= i_data.seed_len;
            end
        end
    end

    // Stage 2 logic: clipped start differences, previous seed ends
    always_comb begin
        n_s2_dq   = (r_s1_q > r_s1_pq) ? (r_s1_q - r_s1_pq) : '0;
        n_s2_dr   = (r_s1_r > r_s1_pr) ? (r_s1_r - r_s1_pr) : '0;
        n_s2_qend = {1'b0, r_s1_pq} + {17'b0, r_s1_plen};
        n_s2_rend = {1'b0, r_s1_pr} + {17'b0, r_s1_plen};
    end

    // Stage 3 logic: indel size, diagonal part, gaps past the previous seed end
    always_comb begin
        if (r_s2_dr == '0) begin
            n_s3_gap  = r_s2_dq;
            n_s3_diag = '0;
        end else if (r_s2_dr < r_s2_dq) begin
            n_s3_gap  = r_s2_dq - r_s2_dr;
            n_s3_diag = r_s2_dr;
        end else begin
            n_s3_gap  = r_s2_dr - r_s2_dq;
            n_s3_diag = r_s2_dq;
        end
        n_s3_gy = ({1'b0, r_s2_q} > r_s2_qend) ? 32'({1'b0, r_s2_q} - r_s2_qend) : '0;
        n_s3_gx = ({1'b0, r_s2_r} > r_s2_rend) ? 32'({1'b0, r_s2_r} - r_s2_rend) : '0;
    end

    // Stage 4 logic: seed, diagonal and gap products; gap area check
    always_comb begin
        n_s4_len_prod  = {16'b0, r_match} * {8'b0, r_s3_len};
        n_s4_diag_prod = r_opt ? ({32'b0, r_match} * {8'b0, r_s3_diag}) : '0;
        n_s4_gap_prod  = {8'b0, r_s3_gap} * {32'b0, r_ext};
        n_s4_too_far   = (r_area != '0) &&
                         (((r_s3_gx > r_area) && (r_s3_gy != '0)) ||
                          ((r_s3_gy > r_area) && (r_s3_gx != '0)));
    end

    // Stage 5 logic: total increment, gap cost, net change, saturated remainder
    always_comb begin
        n_s5_inc      = {17'b0, r_s4_len_prod} + {1'b0, r_s4_diag_prod};
        n_s5_cost     = {1'b0, r_s4_gap_prod} +
                        ((r_s4_gap_prod != '0) ? {31'b0, r_open} : 41'b0);
        n_s5_net      = $signed({1'b0, n_s5_inc}) - $signed({1'b0, n_s5_cost});
        n_s5_sat_cost = SCORE_SAT - {7'b0, n_s5_cost};
    end

    // Shift pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_q     <= i_data.query_start;
            r_s1_r     <= i_data.ref_start;
            r_s1_len   <= i_data.seed_len;
            r_s1_first <= i_data.first_seed;
            r_s1_last  <= i_data.last_seed;
            r_s1_pq    <= r_prev_q;
            r_s1_pr    <= r_prev_r;
            r_s1_plen  <= r_prev_len;

            r_s2_q     <= r_s1_q;
            r_s2_r     <= r_s1_r;
            r_s2_dq    <= n_s2_dq;
            r_s2_dr    <= n_s2_dr;
            r_s2_qend  <= n_s2_qend;
            r_s2_rend  <= n_s2_rend;
            r_s2_len   <= r_s1_len;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;

            r_s3_gap   <= n_s3_gap;
            r_s3_diag  <= n_s3_diag;
            r_s3_gy    <= n_s3_gy;
            r_s3_gx    <= n_s3_gx;
            r_s3_len   <= r_s2_len;
            r_s3_first <= r_s2_first;
            r_s3_last  <= r_s2_last;

            r_s4_len_prod  <= n_s4_len_prod;
            r_s4_diag_prod <= n_s4_diag_prod;
            r_s4_gap_prod  <= n_s4_gap_prod;
            r_s4_too_far   <= n_s4_too_far;
            r_s4_first     <= r_s3_first;
            r_s4_last      <= r_s3_last;

            r_s5_inc      <= n_s5_inc;
            r_s5_net      <= n_s5_net;
            r_s5_sat_cost <= n_s5_sat_cost;
            r_s5_len_prod <= r_s4_len_prod;
            r_s5_too_far  <= r_s4_too_far;
            r_s5_first    <= r_s4_first;
            r_s5_last     <= r_s4_last;
        end
    end

    // Score recurrence: add, charge the gap or restart, track the best segment
    always_comb begin
        w_sum_a = {1'b0, r_run} + {8'b0, r_s5_inc};
        w_sum_b = $signed({2'b0, r_run}) + $signed({{8{r_s5_net[41]}}, r_s5_net});
        if (w_sum_a[SCORE_W]) begin
            w_take = r_s5_too_far;
            w_kept = r_s5_sat_cost;
        end else begin
            w_take = r_s5_too_far || w_sum_b[SCORE_W+1];
            w_kept = w_sum_b[SCORE_W-1:0];
        end
        w_idx = (r_cnt < CNT_MAX) ? r_cnt[IDX_W-1:0] : IDX_MAX;

        n_run = r_run;
        n_max = r_max;
        n_seg = r_seg;
        n_os  = r_os;
        n_oe  = r_oe;
        n_cnt = r_cnt;
        if (r_s5_first || (r_cnt == '0)) begin
            n_cnt = CNT_W'(1);
            n_run = {24'b0, r_s5_len_prod};
            n_max = {24'b0, r_s5_len_prod};
            n_seg = '0;
            n_os  = '0;
            n_oe  = '0;
        end else begin
            if (r_cnt < CNT_MAX) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
            if (w_take) begin
                n_run = '0;
                n_seg = w_idx;
            end else begin
                n_run = w_kept;
            end
            if (n_run > r_max) begin
                n_max = n_run;
                n_os  = n_seg;
                n_oe  = w_idx;
            end
        end

        n_result.best_first_index = 10'(n_os);
        n_result.best_last_index  = 10'(n_oe);
        n_result.best_score       = n_max;
        n_result.seed_count       = 11'(n_cnt);
    end

    // Update chain state once per seed leaving the score stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
            r_max <= '0;
            r_seg <= '0;
            r_os  <= '0;
            r_oe  <= '0;
            r_cnt <= '0;
        end else if (w_adv && r_v5) begin
            r_run <= n_run;
            r_max <= n_max;
            r_seg <= n_seg;
            r_os  <= n_os;
            r_oe  <= n_oe;
            r_cnt <= n_cnt;
        end
    end

    // Load the summary on a last seed; drop it once the output transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_v5 && r_s5_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_v5 && r_s5_last) begin
            r_out <= n_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A new summary appears only after a last seed left the score stage
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_v5 && r_s5_last))
        else $error("summary raised without a last seed");

    // Input stalls only behind a held summary
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall && r_v5 && r_s5_last))
        else $error("input stalled without a blocked summary");

    // Best score never falls below the running score
    a_max_covers_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max >= r_run)
        else $error("best score below running score");

    // Best segment starts no later than it ends, and the count stays in range
    a_segment_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_os <= r_oe) && (r_cnt <= CNT_MAX))
        else $error("best segment bounds or seed count out of order");

endmodule

>>> test/seed_chain_gap_score_filter_tb.sv
`timescale 1ns / 1ps

module seed_chain_gap_score_filter_tb;
    import scgsf_pkg::*;

    localparam int unsigned SEED_CAP    = MAX_SEEDS_DEF;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [63:0] SCORE_CEIL   = {16'd0, SCORE_SAT};

    // One directed seed, with its summary typed in where it is obvious
    typedef struct packed {
        t_seed   seed;
        logic    typed;
        t_result want;
    } t_dir_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SOLID,
        STALL_CHOPPY
    } t_stall_mode;

    localparam t_dir_row DIRECTED [0:14] = '{
        // seed without a chain start right after reset, first and last together
        '{'{32'd100, 32'd200, 16'd10, 1'b0, 1'b1}, 1'b1, '{10'd0, 10'd0, 48'd20, 11'd1}},
        '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1,
          '{10'd0, 10'd0, 48'd131070, 11'd1}},
        // zero-length seeds, no gap
        '{'{32'd0, 32'd0, 16'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{32'd0, 32'd0, 16'd0, 1'b0, 1'b1}, 1'b1, '{10'd0, 10'd0, 48'd0, 11'd2}},
        // diagonal step, small indel, unsorted query start
        '{'{32'd1000, 32'd1000, 16'd50, 1'b1, 1'b0}, 1'b0, '0},
        '{'{32'd1060, 32'd1060, 16'd20, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'd1100, 32'd1090, 16'd20, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'd1090, 32'd1200, 16'd30, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'd1150, 32'd1250, 16'd100, 1'b0, 1'b1}, 1'b0, '0},
        // extreme gaps on each axis drop the score
        '{'{32'd0, 32'd0, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '0},
        '{'{32'hFFFFFFFF, 32'd0, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'd0, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 1'b1}, 1'b1,
          '{10'd0, 10'd0, 48'd131070, 11'd3}},
        // repeated seed, then both starts going backward
        '{'{32'd5, 32'd7, 16'd3, 1'b1, 1'b0}, 1'b0, '0},
        '{'{32'd5, 32'd7, 16'd3, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'd2, 32'd1, 16'd1, 1'b0, 1'b1}, 1'b0, '0}
    };

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    t_seed                 i_data      = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_result               o_data;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_cfg_ready;

    // Register copies
    logic [7:0]  cfg_match      = MATCH_SCORE_RST;
    logic [7:0]  cfg_extend     = EXTEND_PENALTY_RST;
    logic [9:0]  cfg_open       = OPEN_PENALTY_RST;
    logic [31:0] cfg_area       = MAX_GAP_AREA_RST;
    logic        cfg_optimistic = OPTIMISTIC_RST;

    // Chain state of the score scan
    logic [63:0] prev_q      = '0;
    logic [63:0] prev_r      = '0;
    logic [63:0] prev_len    = '0;
    logic [63:0] run_score   = '0;
    logic [63:0] best        = '0;
    logic [63:0] seg_start   = '0;
    logic [63:0] best_first  = '0;
    logic [63:0] best_last   = '0;
    logic [63:0] chain_count = '0;

    t_result     expected_summaries [$];
    t_result     want_now;
    int          n_seeds     = 0;
    int          n_summaries = 0;
    int          n_fail      = 0;
    int          n_settings  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    t_stall_mode stall_mode  = STALL_NONE;

    seed_chain_gap_score_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sat48(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] sum;
        sum = a + b;
        return (sum > SCORE_CEIL) ? SCORE_CEIL : sum;
    endfunction

    // Advance the chain scan by one seed; summary only on a last seed
    function automatic void score_seed(input t_seed s, output bit has_res,
                                       output t_result res);
        logic [63:0] q, r, len, idx, dq, dr, gap, cost, gy, gx, q_end, r_end;
        logic [63:0] match64, ext64, open64, area64, cap64;
        bit          too_far;
        match64 = 64'(cfg_match);
        ext64   = 64'(cfg_extend);
        open64  = 64'(cfg_open);
        area64  = 64'(cfg_area);
        cap64   = 64'(SEED_CAP);
        q   = 64'(s.query_start);
        r   = 64'(s.ref_start);
        len = 64'(s.seed_len);
        if (s.first_seed || chain_count == 0) begin
            chain_count = 1;
            run_score   = match64 * len;
            best        = run_score;
            seg_start   = 0;
            best_first  = 0;
            best_last   = 0;
        end else begin
            if (chain_count < cap64) chain_count = chain_count + 1;
            idx = chain_count - 1;
            if (idx > cap64 - 1) idx = cap64 - 1;
            run_score = sat48(run_score, match64 * len);
            dq  = (q > prev_q) ? q - prev_q : '0;
            dr  = (r > prev_r) ? r - prev_r : '0;
            gap = dq;
            if (dr != 0) begin
                if (dr < dq) begin
                    gap = dq - dr;
                    if (cfg_optimistic) run_score = sat48(run_score, match64 * dr);
                end else begin
                    if (cfg_optimistic) run_score = sat48(run_score, match64 * dq);
                    gap = dr - dq;
                end
            end
            cost = gap * ext64;
            if (cost != 0) cost = cost + open64;
            q_end   = prev_q + prev_len;
            r_end   = prev_r + prev_len;
            gy      = (q > q_end) ? q - q_end : '0;
            gx      = (r > r_end) ? r - r_end : '0;
            too_far = (area64 != 0) &&
                      ((gx > area64 && gy != 0) || (gy > area64 && gx != 0));
            // drop the segment, or pay for the gap
            if (too_far || run_score < cost) begin
                run_score = 0;
                seg_start = idx;
            end else begin
                run_score = run_score - cost;
            end
            if (run_score > best) begin
                best       = run_score;
                best_first = seg_start;
                best_last  = idx;
            end
        end
        prev_q   = q;
        prev_r   = r;
        prev_len = len;
        has_res  = s.last_seed;
        res.best_first_index = best_first[9:0];
        res.best_last_index  = best_last[9:0];
        res.best_score       = best[SCORE_W-1:0];
        res.seed_count       = chain_count[10:0];
    endfunction

    // Send one seed in bursts with random gaps; record its summary on acceptance
    task automatic send_seed(input t_seed s, input bit typed, input t_result want);
        int      gap;
        bit      has_res;
        t_result res;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_seeds++;
        score_seed(s, has_res, res);
        if (has_res) expected_summaries = {expected_summaries, typed ? want : res};
    endtask

    // One register write transaction; the caller lowers valid after the set
    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MATCH_SCORE:    cfg_match      = data[7:0];
            CFG_EXTEND_PENALTY: cfg_extend     = data[7:0];
            CFG_OPEN_PENALTY:   cfg_open       = data[9:0];
            CFG_MAX_GAP_AREA:   cfg_area       = data;
            CFG_OPTIMISTIC:     cfg_optimistic = data[0];
            default: ;
        endcase
    endtask

    // Write all registers back to back, with junk in the unused upper bits
    task automatic program_regs(input logic [7:0] m, input logic [7:0] e,
                                input logic [9:0] o, input logic [31:0] a, input logic opt);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_MATCH_SCORE, {junk[31:8], m});
        junk = $urandom;
        write_reg(CFG_EXTEND_PENALTY, {junk[31:8], e});
        junk = $urandom;
        write_reg(CFG_OPEN_PENALTY, {junk[31:10], o});
        write_reg(CFG_MAX_GAP_AREA, a);
        junk = $urandom;
        write_reg(CFG_OPTIMISTIC, {junk[31:1], opt});
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Hold the seed stream until every summary is back and the pipeline is empty
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Short, mostly sorted chains with random content, plus broken flags and wild jumps
    task automatic run_chains(input int n_items);
        int          left, chain_len;
        logic [31:0] q, r, step;
        t_seed       s;
        left = n_items;
        while (left > 0) begin
            chain_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14);
            if ($urandom_range(0, 4) == 0) begin
                q = $urandom;
                r = $urandom;
            end else begin
                q = $urandom_range(0, 5000);
                r = $urandom_range(0, 5000);
            end
            for (int k = 0; k < chain_len && left > 0; k++) begin
                case ($urandom_range(0, 9))
                    0:       s.seed_len = 16'hFFFF;
                    1:       s.seed_len = 16'($urandom);
                    2:       s.seed_len = 16'd0;
                    default: s.seed_len = 16'($urandom_range(1, 200));
                endcase
                if (k > 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            step = $urandom_range(0, 300);
                            q    = q + step;
                            r    = r + step;
                        end
                        4, 5: begin
                            q = q + $urandom_range(0, 300);
                            r = r + $urandom_range(0, 300);
                        end
                        6: begin
                            q = q + $urandom_range(0, 3000);
                            r = r + $urandom_range(0, 30);
                        end
                        7: begin
                            q = q - $urandom_range(0, 200);
                            r = r + $urandom_range(0, 200);
                        end
                        8: begin
                            q = $urandom;
                            r = $urandom;
                        end
                        default: ;
                    endcase
                end
                s.query_start = q;
                s.ref_start   = r;
                s.first_seed  = (k == 0);
                s.last_seed   = (k == chain_len - 1);
                if ($urandom_range(0, 19) == 0) s.first_seed = ~s.first_seed;
                if ($urandom_range(0, 29) == 0) s.last_seed = ~s.last_seed;
                send_seed(s, 1'b0, '0);
                left--;
            end
        end
    endtask

    // Stimulus
    initial begin
        t_seed       s;
        logic [31:0] q, r, step;
        logic [31:0] area;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) send_seed(DIRECTED[i].seed, DIRECTED[i].typed, DIRECTED[i].want);

        // extreme register settings
        wait_idle();
        program_regs(8'hFF, 8'hFF, 10'h3FF, 32'hFFFFFFFF, 1'b1);
        run_chains(25);
        wait_idle();
        program_regs(8'd0, 8'd0, 10'd0, 32'd0, 1'b0);
        run_chains(25);

        // random register settings
        repeat (6) begin
            wait_idle();
            case ($urandom_range(0, 2))
                0:       area = 32'd0;
                1:       area = $urandom;
                default: area = $urandom_range(1, 800);
            endcase
            program_regs(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(1, 6)),
                         8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 8)),
                         10'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 1023)
                                                         : $urandom_range(0, 20)),
                         area, 1'($urandom_range(0, 1)));
            run_chains(25);
        end

        // long chain past the seed limit, score still climbing at the end
        wait_idle();
        program_regs(8'd3, 8'd1, 10'd2, 32'd0, 1'b0);
        q = $urandom_range(0, 1000);
        r = $urandom_range(0, 1000);
        for (int k = 0; k < SEED_CAP + 6; k++) begin
            s = '{q, r, 16'($urandom_range(1, 100)), k == 0, k == SEED_CAP + 5};
            send_seed(s, 1'b0, '0);
            step = 32'(s.seed_len) + $urandom_range(0, 20);
            q    = q + step;
            r    = r + step;
            if ($urandom_range(0, 19) == 0) r = r + $urandom_range(1, 5);
        end

        // optimistic diagonal jumps between the ends of the axes saturate the score
        wait_idle();
        program_regs(8'hFF, 8'hFF, 10'h3FF, 32'hFFFFFFFF, 1'b1);
        for (int k = 0; k < 540; k++) begin
            q = k[0] ? 32'hFFFFFFFF : 32'd0;
            s = '{q, q, 16'($urandom), k == 0, k == 539};
            send_seed(s, 1'b0, '0);
        end

        wait_idle();
        $display("ran %0d seeds under %0d register settings besides reset;", n_seeds, n_settings);
        $display("checked %0d chain summaries, including long and saturating chains",
                 n_summaries);
        if (n_fail == 0)
            $display("seed_chain_gap_score_filter_tb: PASS");
        else
            $display("seed_chain_gap_score_filter_tb: FAIL");
        $finish;
    end

    // Receiver stall pattern: free stretches, solid stalls, choppy stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    stall_mode = STALL_NONE;
                    stall_left = $urandom_range(10, 60);
                end
                1: begin
                    stall_mode = STALL_SOLID;
                    stall_left = $urandom_range(1, 12);
                end
                default: begin
                    stall_mode = STALL_CHOPPY;
                    stall_left = $urandom_range(5, 30);
                end
            endcase
        end
        stall_left--;
        case (stall_mode)
            STALL_SOLID:  i_stall <= 1'b1;
            STALL_CHOPPY: i_stall <= 1'($urandom_range(0, 1));
            default:      i_stall <= 1'b0;
        endcase
    end

    // Compare each summary transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_summaries.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected summary: first %0d last %0d score %0d count %0d",
                             o_data.best_first_index, o_data.best_last_index,
                             o_data.best_score, o_data.seed_count);
            end else begin
                want_now = expected_summaries.pop_front();
                n_summaries++;
                if (o_data.best_first_index !== want_now.best_first_index ||
                    o_data.best_last_index  !== want_now.best_last_index  ||
                    o_data.best_score       !== want_now.best_score       ||
                    o_data.seed_count       !== want_now.seed_count) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display({"summary mismatch: want first %0d last %0d score %0d ",
                                  "count %0d, got first %0d last %0d score %0d count %0d"},
                                 want_now.best_first_index, want_now.best_last_index,
                                 want_now.best_score, want_now.seed_count,
                                 o_data.best_first_index, o_data.best_last_index,
                                 o_data.best_score, o_data.seed_count);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("seed_chain_gap_score_filter_tb: FAIL");
            $finish;
        end
    end

endmodule

>>> filelist.f
design/scgsf_pkg.sv
design/seed_chain_gap_score_filter.sv
test/seed_chain_gap_score_filter_tb.sv
